@@ hw/rtl/tdpt_pkg.sv @@
// Types and constants shared by the trial division prime test block.
`default_nettype none
package tdpt_pkg;

	localparam int VALUE_BITS_DEF  = 32;
	localparam int TABLE_DEPTH_DEF = 8192;

	localparam int VALUE_W       = 32;
	localparam int TABLE_COUNT_W = 14;

	localparam logic CMD_LOAD = 1'b0;

	typedef struct packed {
		logic               cmd;
		logic [VALUE_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic                     is_prime;
		logic                     appended;
		logic                     table_exhausted;
		logic                     table_full;
		logic [TABLE_COUNT_W-1:0] table_count;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_MOD3,
		ST_DIV,
		ST_EVAL,
		ST_FETCH,
		ST_LOAD,
		ST_FINISH
	} state_t;

endpackage
`default_nettype wire

@@ hw/rtl/trial_division_prime_test.sv @@
// Trial division prime test over a stored table of primes.
//
// Input channel in_valid/in_ready/in_data carries one transaction per item:
// cmd 0 appends value to the prime table; cmd 1 tests value, appending primes.
// Output channel out_valid/out_ready/out_data returns exactly one result per
// item: is_prime, appended, table_exhausted, table_full and the table count.
// Items are handled one at a time. A load, or a test decided by the small-value
// or even rules, finishes from the decide state; a multiple of 3 is caught in
// the mod-3 state (base-4 digit sum, folded). Each table entry visited after
// that takes a fetch, a memory read, the restoring divider (one quotient bit per
// cycle) and an evaluate step; a zero entry is skipped after its read and running
// off the end of the table ends the walk, so the walk length sets the rate.
// The table is a synchronous memory with one read and one write port; its count
// register is cleared by reset, the memory itself is not and needs no clearing.
// The result sits in an output register: in_ready is high again in the cycle the
// result appears, so a new item may start while the receiver stalls.
// If the previous result has not been taken when the next one is ready, the
// block holds in its finish state until out_ready.
`default_nettype none
module trial_division_prime_test
	import tdpt_pkg::*;
#(
	parameter int VALUE_BITS  = VALUE_BITS_DEF,
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int STEP_W = $clog2(VALUE_BITS);
	localparam int DIGITS = (VALUE_BITS + 1) / 2;
	localparam logic [VALUE_BITS-1:0] THREE    = VALUE_BITS'(3);
	localparam logic [VALUE_BITS-1:0] TWO      = VALUE_BITS'(2);
	localparam logic [STEP_W-1:0]     LAST_STEP = STEP_W'(VALUE_BITS - 1);
	localparam logic [CNT_W-1:0]      DEPTH_CNT = CNT_W'(TABLE_DEPTH);

	state_t state_q, state_d;

	logic                  cmd_q;
	logic [VALUE_BITS-1:0] n_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      idx_q;

	// multiple-of-3 check
	logic [7:0]            dsum_q;
	logic [3:0]            fold1;
	logic [2:0]            fold2;
	logic                  mult3;

	// divider
	logic [VALUE_BITS-1:0] d_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [STEP_W-1:0]     step_q;
	logic [VALUE_BITS:0]   shifted;
	logic [VALUE_BITS:0]   diff;
	logic                  ge;

	// pending result
	logic res_prime_q, res_want_q, res_exh_q;

	// memory
	logic [VALUE_BITS-1:0] mem [TABLE_DEPTH];
	logic [VALUE_BITS-1:0] rd_data_q;

	logic                  out_valid_q;
	out_t                  out_q;

	// control
	logic                  res_set, res_prime, res_want, res_exh;
	logic                  div_start;
	logic [VALUE_BITS-1:0] div_divisor;
	logic                  idx_clr, idx_inc, fin;
	logic                  full, we;
	logic [CNT_W-1:0]      cnt_next;

	// 4 == 1 mod 3, so the sum of base-4 digits keeps the residue
	function automatic logic [7:0] digit_sum(input logic [VALUE_BITS-1:0] v);
		logic [2*DIGITS-1:0] w;
		logic [7:0]          s;
		w = '0;
		w[VALUE_BITS-1:0] = v;
		s = '0;
		for (int k = 0; k < DIGITS; k++) begin
			s = s + 8'(w[2*k +: 2]);
		end
		return s;
	endfunction

	assign fold1 = 4'(dsum_q[1:0]) + 4'(dsum_q[3:2]) + 4'(dsum_q[5:4]) + 4'(dsum_q[7:6]);
	assign fold2 = 3'(fold1[1:0]) + 3'(fold1[3:2]);
	assign mult3 = fold2 inside {3'd0, 3'd3, 3'd6};

	assign shifted = {rem_q, quo_q[VALUE_BITS-1]};
	assign diff    = shifted - {1'b0, d_q};
	assign ge      = shifted >= {1'b0, d_q};

	assign full     = (cnt_q >= DEPTH_CNT);
	assign we       = fin && res_want_q && !full;
	assign cnt_next = we ? CNT_W'(cnt_q + 1'b1) : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		res_set     = 1'b0;
		res_prime   = 1'b0;
		res_want    = 1'b0;
		res_exh     = 1'b0;
		div_start   = 1'b0;
		div_divisor = '0;
		idx_clr     = 1'b0;
		idx_inc     = 1'b0;
		fin         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (cmd_q == CMD_LOAD) begin
					res_set  = 1'b1;
					res_want = 1'b1;
					state_d  = ST_FINISH;
				end else if (n_q < TWO) begin
					res_set = 1'b1;
					state_d = ST_FINISH;
				end else if (n_q == TWO || n_q == THREE) begin
					res_set   = 1'b1;
					res_prime = 1'b1;
					res_want  = 1'b1;
					state_d   = ST_FINISH;
				end else if (!n_q[0]) begin
					res_set = 1'b1;
					state_d = ST_FINISH;
				end else begin
					state_d = ST_MOD3;
				end
			end
			ST_MOD3: begin
				if (mult3) begin
					res_set = 1'b1;
					state_d = ST_FINISH;
				end else begin
					idx_clr = 1'b1;
					state_d = ST_FETCH;
				end
			end
			ST_DIV: begin
				if (step_q == LAST_STEP) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (d_q > quo_q) begin
					// entry squared exceeds the candidate
					res_set   = 1'b1;
					res_prime = 1'b1;
					res_want  = 1'b1;
					state_d   = ST_FINISH;
				end else if (rem_q == '0) begin
					res_set = 1'b1;
					state_d = ST_FINISH;
				end else begin
					idx_inc = 1'b1;
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				if (idx_q >= cnt_q) begin
					res_set   = 1'b1;
					res_prime = 1'b1;
					res_want  = 1'b1;
					res_exh   = 1'b1;
					state_d   = ST_FINISH;
				end else begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (rd_data_q == '0) begin
					idx_inc = 1'b1;
					state_d = ST_FETCH;
				end else begin
					div_start   = 1'b1;
					div_divisor = rd_data_q;
					state_d     = ST_DIV;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// walk index, table count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= CNT_W'(idx_q + 1'b1);
			end
			cnt_q <= cnt_next;
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= in_data.cmd;
			n_q   <= VALUE_BITS'(in_data.value);
		end
		if (state_q == ST_DECIDE) begin
			dsum_q <= digit_sum(n_q);
		end
		if (res_set) begin
			res_prime_q <= res_prime;
			res_want_q  <= res_want;
			res_exh_q   <= res_exh;
		end
		if (fin) begin
			out_q.is_prime        <= res_prime_q;
			out_q.appended        <= we;
			out_q.table_exhausted <= res_exh_q;
			out_q.table_full      <= res_want_q && full;
			out_q.table_count     <= TABLE_COUNT_W'(cnt_next);
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (div_start) begin
			d_q    <= div_divisor;
			rem_q  <= '0;
			quo_q  <= n_q;
			step_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q  <= ge ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
			quo_q  <= {quo_q[VALUE_BITS-2:0], ge};
			step_q <= STEP_W'(step_q + 1'b1);
		end
	end

	// prime table
	always_ff @(posedge clk) begin
		if (we) begin
			mem[cnt_q[AW-1:0]] <= n_q;
		end
		rd_data_q <= mem[idx_q[AW-1:0]];
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_CNT)
		else $error("table count beyond depth");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |-> cnt_q == CNT_W'($past(cnt_q) + 1'b1))
		else $error("table count moved by other than one");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> d_q != '0)
		else $error("divide by zero");

	a_read_written: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> idx_q < cnt_q)
		else $error("read of unwritten table entry");

	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.appended && out_data.table_full))
		else $error("appended and full both set");
`endif

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for trial_division_prime_test: directed table and random traffic.
module tb_top;
	import tdpt_pkg::*;

	localparam logic CMD_TEST    = ~CMD_LOAD;
	localparam int   TBL_DEPTH   = TABLE_DEPTH_DEF;
	localparam int   RAND_ITEMS  = 600;
	localparam int   QUIET_LIMIT = 20000;

	typedef struct {
		in_t  item;
		bit   typed;
		out_t want;
	} row_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	// own copy of the prime table
	logic [VALUE_W-1:0] known_primes [TBL_DEPTH];
	int                 known_count = 0;

	out_t results_due [$];
	row_t rows [$];
	out_t want_res;
	bit   steady = 1'b0;
	int   bad_fields = 0;
	int   quiet_cycles = 0;

	trial_division_prime_test dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Judges one item against the table and appends where the rules say so.
	function automatic out_t trial_result(input in_t item);
		out_t               res;
		logic [VALUE_W-1:0] n;
		logic [VALUE_W-1:0] p;
		bit                 decided;
		int                 i;
		res = '0;
		n = item.value;
		if (item.cmd == CMD_TEST) begin
			if (n <= 1)
				res.is_prime = 1'b0;
			else if (n == 2 || n == 3)
				res.is_prime = 1'b1;
			else if (n % 2 == 0 || n % 3 == 0)
				res.is_prime = 1'b0;
			else begin
				decided = 1'b0;
				for (i = 0; i < known_count && !decided; i++) begin
					p = known_primes[i];
					// zero entries are skipped
					if (p != 0) begin
						if (p > n / p) begin
							res.is_prime = 1'b1;
							decided = 1'b1;
						end else if (n % p == 0) begin
							decided = 1'b1;
						end
					end
				end
				if (!decided) begin
					res.is_prime = 1'b1;
					res.table_exhausted = 1'b1;
				end
			end
		end
		if (item.cmd == CMD_LOAD || res.is_prime) begin
			if (known_count < TBL_DEPTH) begin
				known_primes[known_count] = n;
				known_count++;
				res.appended = 1'b1;
			end else begin
				res.table_full = 1'b1;
			end
		end
		res.table_count = TABLE_COUNT_W'(known_count);
		return res;
	endfunction

	function automatic out_t res_of(input int pr, input int ap, input int ex, input int fu,
			input int cnt);
		out_t res;
		res.is_prime = 1'(pr);
		res.appended = 1'(ap);
		res.table_exhausted = 1'(ex);
		res.table_full = 1'(fu);
		res.table_count = TABLE_COUNT_W'(cnt);
		return res;
	endfunction

	task automatic add_row(input logic cmd, input logic [VALUE_W-1:0] value, input bit typed,
			input out_t want);
		row_t r;
		r.item.cmd = cmd;
		r.item.value = value;
		r.typed = typed;
		r.want = want;
		rows.insert(rows.size(), r);
	endtask

	task automatic note_mismatch(input string msg);
		bad_fields++;
		$display("mismatch: %s", msg);
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want)
			note_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	// Presents one transaction, holds it until taken, then records its expected result.
	task automatic offer_item(input in_t item, input bit typed, input out_t want);
		out_t due;
		while (!steady && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		due = trial_result(item);
		results_due.insert(results_due.size(), typed ? want : due);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due.size() != 0);
	endtask

	// Receiver: random stalls, compares each result with the oldest expectation.
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 23);
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				note_mismatch($sformatf("result %h with nothing outstanding", out_data));
			end else begin
				want_res = results_due.pop_front();
				compare_field("is_prime", int'(out_data.is_prime), int'(want_res.is_prime));
				compare_field("appended", int'(out_data.appended), int'(want_res.appended));
				compare_field("table_exhausted", int'(out_data.table_exhausted),
					int'(want_res.table_exhausted));
				compare_field("table_full", int'(out_data.table_full),
					int'(want_res.table_full));
				compare_field("table_count", int'(out_data.table_count),
					int'(want_res.table_count));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		in_t item;
		int  i;
		int  cursor;
		int  pick;

		// opening rows start from an empty table
		add_row(CMD_TEST, 32'd0, 1'b1, res_of(0, 0, 0, 0, 0));
		add_row(CMD_TEST, 32'd1, 1'b1, res_of(0, 0, 0, 0, 0));
		add_row(CMD_TEST, 32'd5, 1'b1, res_of(1, 1, 1, 0, 1));  // empty table runs out
		add_row(CMD_TEST, 32'd2, 1'b1, res_of(1, 1, 0, 0, 2));
		add_row(CMD_TEST, 32'd3, 1'b1, res_of(1, 1, 0, 0, 3));
		add_row(CMD_TEST, 32'd4, 1'b1, res_of(0, 0, 0, 0, 3));
		add_row(CMD_TEST, 32'd9, 1'b1, res_of(0, 0, 0, 0, 3));
		add_row(CMD_TEST, 32'hFFFF_FFFE, 1'b1, res_of(0, 0, 0, 0, 3));
		add_row(CMD_TEST, 32'hFFFF_FFFF, 1'b1, res_of(0, 0, 0, 0, 3));
		add_row(CMD_TEST, 32'd7, 1'b0, '0);
		add_row(CMD_TEST, 32'd25, 1'b0, '0);
		add_row(CMD_TEST, 32'd11, 1'b0, '0);
		add_row(CMD_TEST, 32'd13, 1'b0, '0);
		add_row(CMD_TEST, 32'd35, 1'b0, '0);
		add_row(CMD_LOAD, 32'd17, 1'b1, res_of(0, 1, 0, 0, 7));
		add_row(CMD_LOAD, 32'd19, 1'b1, res_of(0, 1, 0, 0, 8));
		add_row(CMD_LOAD, 32'd0, 1'b1, res_of(0, 1, 0, 0, 9));
		add_row(CMD_LOAD, 32'd19, 1'b1, res_of(0, 1, 0, 0, 10));
		add_row(CMD_TEST, 32'd23, 1'b0, '0);
		add_row(CMD_LOAD, 32'd29, 1'b1, res_of(0, 1, 0, 0, 12));
		add_row(CMD_LOAD, 32'd31, 1'b1, res_of(0, 1, 0, 0, 13));
		add_row(CMD_LOAD, 32'd37, 1'b1, res_of(0, 1, 0, 0, 14));
		add_row(CMD_TEST, 32'd41, 1'b0, '0);
		// a stored one sits behind primes up to 41: only candidates past 41*41 reach it
		add_row(CMD_LOAD, 32'd1, 1'b1, res_of(0, 1, 0, 0, 16));
		add_row(CMD_TEST, 32'd2021, 1'b0, '0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < rows.size(); i++)
			offer_item(rows[i].item, rows[i].typed, rows[i].want);
		drain_results();

		// mostly rising candidates as a host would send them, plus noise
		cursor = 43;
		for (i = 0; i < RAND_ITEMS; i++) begin
			steady = (i >= 250 && i < 370);
			pick = $urandom_range(99);
			item.cmd = CMD_TEST;
			if (pick < 70) begin
				item.value = cursor;
				cursor += $urandom_range(3, 1);
			end else if (pick < 78) begin
				item.value = $urandom;
			end else if (pick < 85) begin
				item.value = $urandom_range(4000);
			end else begin
				item.cmd = CMD_LOAD;
				case ($urandom_range(3))
					0: item.value = $urandom;
					1: item.value = $urandom_range(1);
					2: item.value = known_primes[$urandom_range(known_count - 1)];
					default: item.value = $urandom_range(2000);
				endcase
			end
			offer_item(item, 1'b0, '0);
			if (i % 150 == 149)
				drain_results();
		end
		steady = 1'b0;
		drain_results();
		repeat (60) @(posedge clk);

		if (bad_fields == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
